@@ rtl/core/cps_pkg.sv @@
// Shared types and constants for the closest point on segment block.
package cps_pkg;

   // Coordinate width of every endpoint register and of every input and output coordinate field.
   localparam int unsigned COORD_W = 32;
   // Width of an endpoint or point difference.
   localparam int unsigned DIFF_W = COORD_W + 1;
   // Width of a signed product of two differences.
   localparam int unsigned PROD_W = 2 * DIFF_W;
   // Width of the dividend, divisor and partial remainder of the divider.
   localparam int unsigned DIV_W = PROD_W;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_FIRST_END_X  = 2'd0,
      CSR_FIRST_END_Y  = 2'd1,
      CSR_SECOND_END_X = 2'd2,
      CSR_SECOND_END_Y = 2'd3
   } csr_index_type;

   // Which part of the segment the result came from.
   typedef enum logic [1:0] {
      REGION_INTERIOR = 2'd0,
      REGION_SECOND   = 2'd1,
      REGION_FIRST    = 2'd2,
      REGION_DEGEN    = 2'd3
   } region_type;

   // Side information that travels with a request through the divider.
   typedef struct packed {
      region_type region;
      logic       quot_one;
   } cps_tag_type;

endpackage

@@ rtl/core/cps_div.sv @@
// Pipelined restoring divider that forms the fractional segment position.
module cps_div #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [cps_pkg::DIV_W-1:0]     in_rem,
   input  logic [cps_pkg::DIV_W-1:0]     in_len,
   input  cps_pkg::cps_tag_type          in_tag,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [FRAC_BITS:0]            out_lambda,
   output cps_pkg::cps_tag_type          out_tag
);

   logic                          valid_ff [FRAC_BITS];
   logic [cps_pkg::DIV_W-1:0]     rem_ff   [FRAC_BITS];
   logic [cps_pkg::DIV_W-1:0]     len_ff   [FRAC_BITS];
   logic [FRAC_BITS-1:0]          q_ff     [FRAC_BITS];
   cps_pkg::cps_tag_type          tag_ff   [FRAC_BITS];
   logic [cps_pkg::DIV_W-1:0]     rem_in   [FRAC_BITS];
   logic [FRAC_BITS-1:0]          q_in     [FRAC_BITS];
   logic                          rdy      [FRAC_BITS+1];

   assign rdy[FRAC_BITS] = out_ready;
   assign in_ready       = rdy[0];

   // One quotient bit per stage; a full stage holds while the next is full and stalled.
   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
      logic                      src_valid;
      logic [cps_pkg::DIV_W-1:0] src_rem;
      logic [cps_pkg::DIV_W-1:0] src_len;
      logic [FRAC_BITS-1:0]      src_q;
      cps_pkg::cps_tag_type      src_tag;
      logic [cps_pkg::DIV_W-1:0] shifted;
      logic [cps_pkg::DIV_W-1:0] diff;
      logic                      fits;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_rem;
         assign src_len   = in_len;
         assign src_q     = '0;
         assign src_tag   = in_tag;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_len   = len_ff[k-1];
         assign src_q     = q_ff[k-1];
         assign src_tag   = tag_ff[k-1];
      end

      // Shift the remainder, then subtract the divisor where it fits.
      assign shifted   = {src_rem[cps_pkg::DIV_W-2:0], 1'b0};
      assign fits      = (shifted >= src_len);
      assign diff      = shifted - src_len;
      assign rem_in[k] = fits ? diff : shifted;
      assign q_in[k]   = {src_q[FRAC_BITS-2:0], fits};
      assign rdy[k]    = !valid_ff[k] || rdy[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && src_valid) begin
            rem_ff[k] <= rem_in[k];
            len_ff[k] <= src_len;
            q_ff[k]   <= q_in[k];
            tag_ff[k] <= src_tag;
         end
      end
   end

   // A dividend equal to the divisor gives exactly one.
   assign out_valid  = valid_ff[FRAC_BITS-1];
   assign out_tag    = tag_ff[FRAC_BITS-1];
   assign out_lambda = tag_ff[FRAC_BITS-1].quot_one ? {1'b1, {FRAC_BITS{1'b0}}}
                                                   : {1'b0, q_ff[FRAC_BITS-1]};

endmodule

@@ rtl/core/closest_point_on_segment.sv @@
// Throughput: one request per cycle while rsp_tready holds; the FRAC_BITS-stage divider
// takes one quotient bit per stage, and the two product stages multiply 33-bit differences.
// Each stage stalls only when it is full and the stage after it is stalled.
// Synchronous reset empties the pipeline and clears all four endpoint registers to zero.
module closest_point_on_segment #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // point_x [31:0], point_y [63:32]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // near_x [31:0], near_y [63:32]
   output logic [1:0]  rsp_tuser,  // region [1:0]
   // Configuration port.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned CW    = cps_pkg::COORD_W;
   localparam int unsigned DW    = cps_pkg::DIFF_W;
   localparam int unsigned PW    = cps_pkg::PROD_W;
   localparam int unsigned LAM_W = FRAC_BITS + 1;
   localparam int unsigned MUL_W = DW + LAM_W + 1;

   // Endpoint registers.
   logic signed [CW-1:0] ax_ff, ay_ff, bx_ff, by_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0;
         ay_ff <= '0;
         bx_ff <= '0;
         by_ff <= '0;
      end else if (csr_we) begin
         case (cps_pkg::csr_index_type'(csr_index))
            cps_pkg::CSR_FIRST_END_X:  ax_ff <= csr_wdata;
            cps_pkg::CSR_FIRST_END_Y:  ay_ff <= csr_wdata;
            cps_pkg::CSR_SECOND_END_X: bx_ff <= csr_wdata;
            cps_pkg::CSR_SECOND_END_Y: by_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Segment direction; the user must change the endpoints only while the pipeline is empty (not enforced).
   logic signed [DW-1:0] tx, ty;
   logic                 degen;

   assign tx    = {ax_ff[CW-1], ax_ff} - {bx_ff[CW-1], bx_ff};
   assign ty    = {ay_ff[CW-1], ay_ff} - {by_ff[CW-1], by_ff};
   assign degen = (tx == '0) && (ty == '0);

   // Ready chain, one term per stage.
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   // Stage 1: offset of the point from the second endpoint.
   logic                 v1_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic                 degen1_ff;
   logic signed [CW-1:0] px, py;

   assign px    = req_tdata[31:0];
   assign py    = req_tdata[63:32];
   assign dx_in = {px[CW-1], px} - {bx_ff[CW-1], bx_ff};
   assign dy_in = {py[CW-1], py} - {by_ff[CW-1], by_ff};
   assign rdy1  = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         degen1_ff <= degen;
      end
   end

   // Stage 2: the four products of the dot product and squared length.
   logic                 v2_ff;
   logic signed [PW-1:0] dtx_ff, dty_ff, ttx_ff, tty_ff;
   logic signed [PW-1:0] dtx_in, dty_in, ttx_in, tty_in;
   logic                 degen2_ff;

   assign dtx_in = PW'(dx_ff) * PW'(tx);
   assign dty_in = PW'(dy_ff) * PW'(ty);
   assign ttx_in = PW'(tx) * PW'(tx);
   assign tty_in = PW'(ty) * PW'(ty);
   assign rdy2   = !v2_ff || rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         dtx_ff    <= dtx_in;
         dty_ff    <= dty_in;
         ttx_ff    <= ttx_in;
         tty_ff    <= tty_in;
         degen2_ff <= degen1_ff;
      end
   end

   // Stage 3: sum the products.
   logic                   v3_ff;
   logic signed [PW:0]     dot_ff, dot_in;
   logic [PW-1:0]          len_ff, len_in;
   logic                   degen3_ff;

   assign dot_in = {dtx_ff[PW-1], dtx_ff} + {dty_ff[PW-1], dty_ff};
   assign len_in = ttx_ff + tty_ff;
   assign rdy3   = !v3_ff || rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         dot_ff    <= dot_in;
         len_ff    <= len_in;
         degen3_ff <= degen2_ff;
      end
   end

   // Stage 4: clamp decision against both ends of the segment.
   logic                 v4_ff;
   logic [PW-1:0]        dotu_ff, dotu_in;
   logic [PW-1:0]        len4_ff;
   cps_pkg::cps_tag_type tag4_ff, tag4_in;
   logic                 div_in_ready;

   assign dotu_in = dot_ff[PW-1:0];

   always_comb begin
      tag4_in.quot_one = (dotu_in >= len_ff);
      if (degen3_ff) begin
         tag4_in.region = cps_pkg::REGION_DEGEN;
      end else if (dot_ff[PW]) begin
         tag4_in.region = cps_pkg::REGION_SECOND;
      end else if (dotu_in > len_ff) begin
         tag4_in.region = cps_pkg::REGION_FIRST;
      end else begin
         tag4_in.region = cps_pkg::REGION_INTERIOR;
      end
   end

   assign rdy4 = !v4_ff || div_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         dotu_ff <= dotu_in;
         len4_ff <= len_ff;
         tag4_ff <= tag4_in;
      end
   end

   // Divider: lambda = floor(dot * 2^FRAC_BITS / len).
   logic                 div_out_valid;
   logic [LAM_W-1:0]     div_lambda;
   cps_pkg::cps_tag_type div_tag;

   cps_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v4_ff),
      .in_ready   (div_in_ready),
      .in_rem     (dotu_ff),
      .in_len     (len4_ff),
      .in_tag     (tag4_ff),
      .out_valid  (div_out_valid),
      .out_ready  (rdy5),
      .out_lambda (div_lambda),
      .out_tag    (div_tag)
   );

   // Stage 5: scale the direction by lambda.
   logic                    v5_ff;
   logic signed [MUL_W-1:0] offx_ff, offy_ff, offx_in, offy_in;
   logic signed [LAM_W:0]   lambda_s;
   cps_pkg::region_type     region5_ff;

   assign lambda_s = {1'b0, div_lambda};
   assign offx_in  = MUL_W'(tx) * MUL_W'(lambda_s);
   assign offy_in  = MUL_W'(ty) * MUL_W'(lambda_s);
   assign rdy5     = !v5_ff || rdy6;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (rdy5) begin
         v5_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5 && div_out_valid) begin
         offx_ff    <= offx_in;
         offy_ff    <= offy_in;
         region5_ff <= div_tag.region;
      end
   end

   // Stage 6: output register with the floor-shifted offset and the clamp select.
   logic                v6_ff;
   logic [CW-1:0]       nearx_ff, neary_ff, nearx_in, neary_in;
   cps_pkg::region_type region6_ff;

   always_comb begin
      case (region5_ff)
         cps_pkg::REGION_INTERIOR: begin
            nearx_in = bx_ff + offx_ff[FRAC_BITS +: CW];
            neary_in = by_ff + offy_ff[FRAC_BITS +: CW];
         end
         cps_pkg::REGION_SECOND: begin
            nearx_in = bx_ff;
            neary_in = by_ff;
         end
         default: begin
            nearx_in = ax_ff;
            neary_in = ay_ff;
         end
      endcase
   end

   assign rdy6 = !v6_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (rdy6) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6 && v5_ff) begin
         nearx_ff   <= nearx_in;
         neary_ff   <= neary_in;
         region6_ff <= region5_ff;
      end
   end

   assign rsp_tvalid = v6_ff;
   assign rsp_tdata  = {neary_ff, nearx_ff};
   assign rsp_tuser  = region6_ff;

endmodule
